[hw/rtl/ch3d_pkg.sv]
// ----------------------------------------------------------------------------
// ch3d_pkg
// Shared types, pipeline depths and bit helpers for the 3D coordinate hash.
// ----------------------------------------------------------------------------
package ch3d_pkg;

  // Register stages of one mixer (five 64-bit multiplies, two stages each)
  localparam int unsigned MIX_LAT = 10;
  // Register stages of the modulo / fraction back end
  localparam int unsigned RED_LAT = 10;

  typedef struct packed {
    logic signed [31:0] coord_x;
    logic signed [31:0] coord_y;
    logic signed [31:0] coord_z;
  } coord_t;

  typedef struct packed {
    logic [63:0] mixed_hash;
    logic [24:0] residue;
    logic [31:0] unit_fraction;
  } res_t;

  // Rotate right; an amount of zero passes the value through.
  function automatic logic [63:0] rotr64(input logic [63:0] v, input logic [5:0] r);
    return (v >> r) | (v << (7'd64 - {1'b0, r}));
  endfunction

endpackage

[hw/rtl/ch3d_mul64.sv]
// ----------------------------------------------------------------------------
// ch3d_mul64
// Two-stage 64 x 64 multiply keeping the low 64 bits of the product.
// ----------------------------------------------------------------------------
module ch3d_mul64 (
  input  logic        clk_i,
  input  logic [63:0] a_i,
  input  logic [63:0] c_i,
  output logic [63:0] p_o
);

  logic [63:0] ll_d, ll_q;
  logic [31:0] lh_d, lh_q;
  logic [31:0] hl_d, hl_q;
  logic [63:0] p_d, p_q;

  // Stage 1: the three 32 x 32 partial products that reach the low 64 bits
  assign ll_d = 64'(a_i[31:0]) * 64'(c_i[31:0]);
  assign lh_d = a_i[31:0] * c_i[63:32];
  assign hl_d = a_i[63:32] * c_i[31:0];

  // Stage 2: cross terms land in the upper word, carries out of bit 63 drop
  assign p_d = ll_q + {lh_q + hl_q, 32'd0};

  always_ff @(posedge clk_i) begin
    ll_q <= ll_d;
    lh_q <= lh_d;
    hl_q <= hl_d;
    p_q  <= p_d;
  end

  assign p_o = p_q;

endmodule

[hw/rtl/ch3d_mix.sv]
// ----------------------------------------------------------------------------
// ch3d_mix
// 64-bit mixer: FNV xor/multiply, rotate, and multiply/xorshift finalizer.
// ----------------------------------------------------------------------------
module ch3d_mix (
  input  logic        clk_i,
  input  logic [63:0] v_i,
  output logic [63:0] v_o
);

  localparam logic [63:0] FNV_OFFSET = 64'hcbf29ce484222325;
  localparam logic [63:0] FNV_PRIME  = 64'h00000100000001b3;
  localparam logic [63:0] MIX_MUL_A  = 64'hbf58476d1ce4e5b9;
  localparam logic [63:0] MIX_MUL_B  = 64'h94d049bb133111eb;
  localparam logic [5:0]  ROT_MIX    = 6'd27;

  logic [63:0] in1, in2, in4, in5;
  logic [63:0] p1, p2, p3, p4;

  assign in1 = v_i ^ FNV_OFFSET;
  ch3d_mul64 u_mul1 (.clk_i(clk_i), .a_i(in1), .c_i(FNV_PRIME), .p_o(p1));

  assign in2 = ch3d_pkg::rotr64(p1, ROT_MIX);
  ch3d_mul64 u_mul2 (.clk_i(clk_i), .a_i(in2), .c_i(FNV_PRIME), .p_o(p2));

  ch3d_mul64 u_mul3 (.clk_i(clk_i), .a_i(p2), .c_i(MIX_MUL_A), .p_o(p3));

  assign in4 = p3 ^ (p3 >> 32);
  ch3d_mul64 u_mul4 (.clk_i(clk_i), .a_i(in4), .c_i(MIX_MUL_B), .p_o(p4));

  assign in5 = p4 ^ (p4 >> 32);
  ch3d_mul64 u_mul5 (.clk_i(clk_i), .a_i(in5), .c_i(MIX_MUL_B), .p_o(v_o));

endmodule

[hw/rtl/ch3d_reduce.sv]
// ----------------------------------------------------------------------------
// ch3d_reduce
// Residue of the hash modulo 24432403 and its Q0.32 fraction of the maximum.
// ----------------------------------------------------------------------------
module ch3d_reduce (
  input  logic              clk_i,
  input  logic [63:0]       hash_i,
  output ch3d_pkg::res_t    res_o
);

  localparam logic [24:0] RES_PRIME  = 25'd24432403;
  localparam logic [24:0] FRAC_DIV   = 25'd24432402;
  // 2^32 mod prime, used to fold the upper word back in
  localparam logic [24:0] RES_FOLD   = 25'((64'd1 << 32) % 64'(RES_PRIME));
  // floor(2^40 / prime) and floor(2^57 / divisor), estimates low by at most one
  localparam logic [15:0] RES_RECIP  = 16'((64'd1 << 40) / 64'(RES_PRIME));
  localparam logic [32:0] FRAC_RECIP = 33'((64'd1 << 57) / 64'(FRAC_DIV));
  localparam int unsigned HASH_DLY   = ch3d_pkg::RED_LAT - 1;

  // Folding stages: value stays congruent to the hash, shrinks each stage
  logic [56:0] f1_prod;
  logic [50:0] f2_prod;
  logic [44:0] f3_prod;
  logic [38:0] f4_prod;
  logic [57:0] t1_q;
  logic [51:0] t2_q;
  logic [45:0] t3_q;
  logic [39:0] t4_q, t5_q;
  // Reciprocal quotient estimate and correction
  logic [55:0] qe_prod;
  logic [15:0] qe_q;
  logic [40:0] qp_prod;
  logic [40:0] rr_full;
  logic [25:0] rr_q;
  logic [24:0] r_d, r_q;
  // Fraction
  logic [57:0] fq_prod;
  logic [31:0] fq_q, fq_f2_q;
  logic [24:0] r_f1_q, r_f2_q;
  logic [56:0] fp_d, fp_q;
  logic [56:0] rem_d;
  logic [31:0] frac_d;
  logic [63:0] hash_dly_q [HASH_DLY];
  ch3d_pkg::res_t res_q;

  assign f1_prod = 57'(hash_i[63:32]) * 57'(RES_FOLD);
  assign f2_prod = 51'(t1_q[57:32]) * 51'(RES_FOLD);
  assign f3_prod = 45'(t2_q[51:32]) * 45'(RES_FOLD);
  assign f4_prod = 39'(t3_q[45:32]) * 39'(RES_FOLD);

  assign qe_prod = 56'(t4_q) * 56'(RES_RECIP);
  assign qp_prod = 41'(qe_q) * 41'(RES_PRIME);
  assign rr_full = 41'(t5_q) - qp_prod;

  // Estimate is exact or one low, so one compare-subtract finishes the job
  assign r_d = (rr_q >= 26'(RES_PRIME)) ? 25'(rr_q - 26'(RES_PRIME)) : rr_q[24:0];

  assign fq_prod = 58'(r_q) * 58'(FRAC_RECIP);
  assign fp_d    = 57'(fq_q) * 57'(FRAC_DIV);
  assign rem_d   = {r_f2_q, 32'd0} - fp_q;

  always_comb begin
    if (r_f2_q >= FRAC_DIV) begin
      frac_d = '1;  // residue at maximum means 1.0: saturate
    end else if (rem_d >= 57'(FRAC_DIV)) begin
      frac_d = fq_f2_q + 32'd1;
    end else begin
      frac_d = fq_f2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    t1_q    <= 58'(f1_prod) + 58'(hash_i[31:0]);
    t2_q    <= 52'(f2_prod) + 52'(t1_q[31:0]);
    t3_q    <= 46'(f3_prod) + 46'(t2_q[31:0]);
    t4_q    <= 40'(f4_prod) + 40'(t3_q[31:0]);
    qe_q    <= qe_prod[55:40];
    t5_q    <= t4_q;
    rr_q    <= rr_full[25:0];
    r_q     <= r_d;
    fq_q    <= fq_prod[56:25];
    r_f1_q  <= r_q;
    fp_q    <= fp_d;
    fq_f2_q <= fq_q;
    r_f2_q  <= r_f1_q;

    hash_dly_q[0] <= hash_i;
    for (int i = 1; i < HASH_DLY; i++) begin
      hash_dly_q[i] <= hash_dly_q[i-1];
    end

    res_q.mixed_hash    <= hash_dly_q[HASH_DLY-1];
    res_q.residue       <= r_f2_q;
    res_q.unit_fraction <= frac_d;
  end

  assign res_o = res_q;

endmodule

[hw/rtl/coordinate_hash_3d.sv]
// ----------------------------------------------------------------------------
// coordinate_hash_3d
// Seeded 64-bit hash of a signed 3D lattice coordinate, with residue and
// Q0.32 fraction outputs.
// ----------------------------------------------------------------------------
// Usage:
//   Input: a coordinate beat is taken at a rising edge with start high and
//   busy low. busy is always low: the pipeline takes one beat per cycle,
//   every cycle, with no gaps needed between beats.
//   Config: world_seed is written when cfg_valid_i and cfg_ready_o are both
//   high; cfg_ready_o is always high. Write it only with no beat in flight.
//   Output: each result sits on result_o for one cycle with done_o high.
//   Results leave in input order.
//   Throughput is one beat per cycle; latency is set by the three chained
//   mixers (10 stages each: five 64-bit multiplies of two stages) plus
//   10 stages of modulo and fraction arithmetic and the input register.
//   The receiver cannot stall, so nothing here ever holds or repeats.
//   Reset clears the valid pipeline and sets world_seed to zero; data
//   registers are not reset and carry no meaning while done_o is low.
// ----------------------------------------------------------------------------
module coordinate_hash_3d (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  output logic              busy,
  input  ch3d_pkg::coord_t  coord_i,
  input  logic              cfg_valid_i,
  output logic              cfg_ready_o,
  input  logic [31:0]       cfg_data_i,
  output logic              done_o,
  output ch3d_pkg::res_t    result_o
);

  localparam int unsigned PIPE_DEPTH = 1 + 3 * ch3d_pkg::MIX_LAT + ch3d_pkg::RED_LAT;
  localparam logic [5:0]  ROT_PAIR   = 6'd32;
  localparam logic [5:0]  ROT_H2     = 6'd17;
  localparam logic [5:0]  ROT_H3     = 6'd29;
  localparam logic [5:0]  ROT_FINAL  = 6'd7;

  function automatic logic [63:0] sext32(input logic [31:0] v);
    return {{32{v[31]}}, v};
  endfunction

  logic                  accept;
  logic [31:0]           world_seed_q;
  logic [PIPE_DEPTH-1:0] vld_q;

  // Input stage
  logic [63:0] x0_q, y0_q, z0_q;
  logic [31:0] seed0_q;
  // Seed rides alongside level 1 so its mix lines up with the pair hashes
  logic [31:0] seed_dly_q [ch3d_pkg::MIX_LAT];

  logic [63:0] l1_in  [6];
  logic [63:0] l1_out [6];
  logic [63:0] l2_in  [4];
  logic [63:0] l2_out [4];
  logic [63:0] comb_h;
  logic [63:0] l3_in, l3_out;

  // Never stalls: downstream cannot push back and every stage moves each cycle
  assign busy        = 1'b0;
  assign cfg_ready_o = 1'b1;
  assign accept      = start & ~busy;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      world_seed_q <= '0;
      vld_q        <= '0;
    end else begin
      if (cfg_valid_i && cfg_ready_o) begin
        world_seed_q <= cfg_data_i;
      end
      vld_q <= {vld_q[PIPE_DEPTH-2:0], accept};
    end
  end

  // Input register: sign-extend and snapshot the seed with the beat
  always_ff @(posedge clk_i) begin
    if (accept) begin
      x0_q    <= sext32(coord_i.coord_x);
      y0_q    <= sext32(coord_i.coord_y);
      z0_q    <= sext32(coord_i.coord_z);
      seed0_q <= world_seed_q;
    end
    seed_dly_q[0] <= seed0_q;
    for (int i = 1; i < ch3d_pkg::MIX_LAT; i++) begin
      seed_dly_q[i] <= seed_dly_q[i-1];
    end
  end

  // Level 1: mix of each coordinate and of its word-swapped copy.
  // Pairs (x,y), (y,z), (z,x) reuse these six lanes.
  always_comb begin
    l1_in[0] = x0_q;
    l1_in[1] = ch3d_pkg::rotr64(y0_q, ROT_PAIR);
    l1_in[2] = y0_q;
    l1_in[3] = ch3d_pkg::rotr64(z0_q, ROT_PAIR);
    l1_in[4] = z0_q;
    l1_in[5] = ch3d_pkg::rotr64(x0_q, ROT_PAIR);
  end

  for (genvar i = 0; i < 6; i++) begin : g_l1
    ch3d_mix u_mix (.clk_i(clk_i), .v_i(l1_in[i]), .v_o(l1_out[i]));
  end

  // Level 2: pair hashes mix(mix(a) | mix(ror32(b))) plus the seed mix
  always_comb begin
    l2_in[0] = l1_out[0] | l1_out[1];
    l2_in[1] = l1_out[2] | l1_out[3];
    l2_in[2] = l1_out[4] | l1_out[5];
    l2_in[3] = sext32(seed_dly_q[ch3d_pkg::MIX_LAT-1]);
  end

  for (genvar i = 0; i < 4; i++) begin : g_l2
    ch3d_mix u_mix (.clk_i(clk_i), .v_i(l2_in[i]), .v_o(l2_out[i]));
  end

  // Level 3: combine pair hashes with the seed, rotate, remix
  assign comb_h = l2_out[0]
                ^ ch3d_pkg::rotr64(l2_out[1], ROT_H2)
                ^ ch3d_pkg::rotr64(l2_out[2], ROT_H3)
                ^ l2_out[3];
  assign l3_in  = ch3d_pkg::rotr64(comb_h, ROT_FINAL);

  ch3d_mix u_mix_final (.clk_i(clk_i), .v_i(l3_in), .v_o(l3_out));

  // Back end: residue, fraction, and the hash delayed to match
  ch3d_reduce u_reduce (
    .clk_i (clk_i),
    .hash_i(l3_out),
    .res_o (result_o)
  );

  assign done_o = vld_q[PIPE_DEPTH-1];

endmodule
